// ----- rtl/packed_handle_table_defines.svh -----
// Assertion macros shared by the handle table RTL.
`ifndef PACKED_HANDLE_TABLE_DEFINES_SVH
`define PACKED_HANDLE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define PHT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("packed_handle_table: check failed");
`define PHT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("packed_handle_table: check failed");
`else
`define PHT_ASSERT(lbl, clk, rst, prop)
`define PHT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/pht_pkg.sv -----
// Shared constants and codes for the packed handle table.
`timescale 1ns / 1ps
package pht_pkg;

  localparam int MAX_ENTRIES_DEF = 512;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_LIVE = 2'd2,
    ST_BAD_SLOT = 2'd3
  } status_t;

endpackage

// ----- rtl/pht_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps
module pht_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/pht_dense.sv -----
// Dense slot array: live handles below the count, free stack (reversed) above it.
`timescale 1ns / 1ps
`include "packed_handle_table_defines.svh"
module pht_dense import pht_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int HW = $clog2(MAX_ENTRIES),
  localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [HW-1:0] waddr,
  input  logic [HW-1:0] wdata,
  input  logic [HW-1:0] raddr,
  output logic [HW-1:0] rdata
);

  localparam logic [HW-1:0] TopHandle = HW'(MAX_ENTRIES - 1);

  // high-water mark: entries at or above it were never written and still
  // hold their reset value, slot k holding handle MAX_ENTRIES-1-k
  logic [CW-1:0] hw;
  logic          fresh;
  logic [HW-1:0] raddr_q;
  logic [HW-1:0] ram_rdata;

  pht_ram #(.WIDTH(HW), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hw <= '0;
    end else if (we && CW'(waddr) >= hw) begin
      hw <= CW'(waddr) + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    fresh   <= CW'(raddr) >= hw;
    raddr_q <= raddr;
  end

  assign rdata = fresh ? (TopHandle - raddr_q) : ram_rdata;

  `PHT_ASSERT(a_write_reach, clk, rst, we |-> (CW'(waddr) <= hw))
  `PHT_ASSERT_NEXT(a_hw_monotone, clk, rst, 1'b1, hw >= $past(hw))
  `PHT_ASSERT(a_hw_bound, clk, rst, hw <= CW'(MAX_ENTRIES))

endmodule

// ----- rtl/packed_handle_table.sv -----
// Packed handle table top level: command sequencer over the slot and handle memories.
// Usage:
//   Input channel (in_valid/in_ready) carries one command word: command,
//   handle_in, slot_in. Output channel (out_valid/out_ready) returns one
//   result word per command: status, handle_out, slot_out, live_count_out.
//   Allocate pops the next free handle and packs it at slot live_count.
//   Free checks that the handle is live, swaps the last live handle into
//   its slot and pushes it back. Read returns the handle at a dense slot.
// Sequencing:
//   Allocate, read and the unused code pass from S_A to S_OUT; a free
//   goes through S_A, S_B and S_C, or leaves for S_OUT from S_A or S_B
//   when rejected. The memories have registered reads: a free reads the
//   handle's slot, then the slot's owner, then writes the dense memory twice.
//   A new word is taken while a finished result waits in the output
//   register; if the receiver stalls, the next result holds in the
//   sequencer and no further word is taken until the output drains.
// Reset:
//   Synchronous, active high. Clears the count and the control state; no
//   memory sweep is needed, untouched dense slots are served from a
//   high-water mark, so commands are taken in the first cycle after reset.
`timescale 1ns / 1ps
`include "packed_handle_table_defines.svh"
module packed_handle_table import pht_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int HW = $clog2(MAX_ENTRIES),
  localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    command,
  input  logic [HW-1:0] handle_in,
  input  logic [HW-1:0] slot_in,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    status,
  output logic [HW-1:0] handle_out,
  output logic [HW-1:0] slot_out,
  output logic [CW-1:0] live_count_out
);

  localparam logic [CW-1:0] Full = CW'(MAX_ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_A    = 5'b00010,
    S_B    = 5'b00100,
    S_C    = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] live, live_next;
  cmd_t          cmd_q;
  logic [HW-1:0] hin_q, sin_q;
  logic [HW-1:0] moved, moved_next;
  logic [HW-1:0] slot, slot_next;
  status_t       res_status, res_status_next;
  logic [HW-1:0] res_handle, res_handle_next;
  logic [HW-1:0] res_slot, res_slot_next;
  logic [CW-1:0] res_count, res_count_next;

  logic          load, accept;
  logic          d_we, s_we;
  logic [HW-1:0] d_waddr, d_wdata, d_raddr, d_rdata;
  logic [HW-1:0] s_waddr, s_wdata, s_rdata;
  logic [HW-1:0] live_lo;

  assign live_lo  = live[HW-1:0];
  assign load     = (state == S_OUT) && (!out_valid || out_ready);
  assign in_ready = (state == S_IDLE) || load;
  assign accept   = in_valid && in_ready;

  // dense array: slot -> handle, free stack above the live count
  pht_dense #(.MAX_ENTRIES(MAX_ENTRIES)) u_dense (
    .clk   (clk),
    .rst   (rst),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  // sparse array: handle -> slot
  pht_ram #(.WIDTH(HW), .DEPTH(MAX_ENTRIES)) u_sparse (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (handle_in),
    .rdata (s_rdata)
  );

  always_comb begin
    if (state == S_A) begin
      d_raddr = s_rdata;
    end else begin
      case (cmd_t'(command))
        CMD_FREE: d_raddr = live_lo - 1'b1;
        CMD_READ: d_raddr = slot_in;
        default:  d_raddr = live_lo;
      endcase
    end
  end

  always_comb begin
    state_next      = state;
    live_next       = live;
    moved_next      = moved;
    slot_next       = slot;
    res_status_next = res_status;
    res_handle_next = res_handle;
    res_slot_next   = res_slot;
    res_count_next  = res_count;
    d_we            = 1'b0;
    d_waddr         = live_lo;
    d_wdata         = hin_q;
    s_we            = 1'b0;
    s_waddr         = moved;
    s_wdata         = slot;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_A;
        end
      end
      S_A: begin
        state_next      = S_OUT;
        res_status_next = ST_OK;
        res_handle_next = '0;
        res_slot_next   = '0;
        res_count_next  = live;
        case (cmd_q)
          CMD_ALLOC: begin
            if (live == Full) begin
              res_status_next = ST_FULL;
            end else begin
              d_we            = 1'b1;
              d_waddr         = live_lo;
              d_wdata         = d_rdata;
              s_we            = 1'b1;
              s_waddr         = d_rdata;
              s_wdata         = live_lo;
              live_next       = live + 1'b1;
              res_handle_next = d_rdata;
              res_slot_next   = live_lo;
              res_count_next  = live + 1'b1;
            end
          end
          CMD_FREE: begin
            moved_next = d_rdata;
            slot_next  = s_rdata;
            // slot at or past the count also covers an empty table
            if (CW'(s_rdata) >= live) begin
              res_status_next = ST_NOT_LIVE;
            end else begin
              state_next = S_B;
            end
          end
          CMD_READ: begin
            res_slot_next = sin_q;
            if (CW'(sin_q) >= live) begin
              res_status_next = ST_BAD_SLOT;
            end else begin
              res_handle_next = d_rdata;
            end
          end
          default: begin
          end
        endcase
      end
      S_B: begin
        if (d_rdata != hin_q) begin
          res_status_next = ST_NOT_LIVE;
          state_next      = S_OUT;
        end else begin
          // last live handle takes over the freed slot
          d_we            = 1'b1;
          d_waddr         = slot;
          d_wdata         = moved;
          s_we            = 1'b1;
          s_waddr         = moved;
          s_wdata         = slot;
          live_next       = live - 1'b1;
          res_handle_next = moved;
          res_slot_next   = slot;
          res_count_next  = live - 1'b1;
          state_next      = S_C;
        end
      end
      S_C: begin
        // push the freed handle just above the new count
        d_we       = 1'b1;
        d_waddr    = live_lo;
        d_wdata    = hin_q;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (load) begin
          state_next = accept ? S_A : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      live      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      live      <= live_next;
      out_valid <= load || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd_t'(command);
      hin_q <= handle_in;
      sin_q <= slot_in;
    end
    moved      <= moved_next;
    slot       <= slot_next;
    res_status <= res_status_next;
    res_handle <= res_handle_next;
    res_slot   <= res_slot_next;
    res_count  <= res_count_next;
    if (load) begin
      status         <= res_status;
      handle_out     <= res_handle;
      slot_out       <= res_slot;
      live_count_out <= res_count;
    end
  end

  `PHT_ASSERT(a_live_bound, clk, rst, live <= Full)
  `PHT_ASSERT(a_busy_no_take, clk, rst, (state == S_A || state == S_B || state == S_C) |-> !in_ready)
  `PHT_ASSERT_NEXT(a_alloc_count, clk, rst, state == S_A && cmd_q == CMD_ALLOC && live != Full, live == $past(live) + 1'b1)
  `PHT_ASSERT_NEXT(a_free_count, clk, rst, state == S_B && d_rdata == hin_q, live == $past(live) - 1'b1)

endmodule

// ----- verif/packed_handle_table_tb.sv -----
// Self-checking testbench for the packed handle table: directed, fill/drain and random traffic.
`timescale 1ns / 1ps
module packed_handle_table_tb import pht_pkg::*; ();

  localparam int TABLE_SIZE  = MAX_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_WORDS = 500;

  typedef struct packed {
    status_t    st;
    logic [8:0] hnd;
    logic [8:0] slot;
    logic [9:0] count;
  } table_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] command = CMD_NONE;
  logic [8:0] handle_in = '0;
  logic [8:0] slot_in = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] status;
  logic [8:0] handle_out;
  logic [8:0] slot_out;
  logic [9:0] live_count_out;

  packed_handle_table uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .handle_in      (handle_in),
    .slot_in        (slot_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .handle_out     (handle_out),
    .slot_out       (slot_out),
    .live_count_out (live_count_out)
  );

  // Mirror of the allocator state
  logic [8:0] free_list [TABLE_SIZE];
  logic [8:0] slot_of   [TABLE_SIZE];
  logic [8:0] handle_at [TABLE_SIZE];
  bit         touched   [TABLE_SIZE];
  int         free_cnt;
  int         live_n;

  table_result_t pending_results[$];

  int errors = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int n_alloc = 0, n_free = 0, n_read = 0, n_idle = 0;
  int n_full = 0, n_not_live = 0, n_bad_slot = 0, peak_live = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void reset_mirror();
    for (int i = 0; i < TABLE_SIZE; i++) begin
      free_list[i] = 9'(i);
      slot_of[i]   = '0;
      handle_at[i] = '0;
      touched[i]   = 1'b0;
    end
    free_cnt = TABLE_SIZE;
    live_n   = 0;
  endfunction

  function automatic bit handle_is_live(logic [8:0] h);
    logic [8:0] s;
    s = slot_of[h];
    return (int'(s) < live_n) && (handle_at[s] == h);
  endfunction

  // Applies one command word to the mirror and returns the expected result word.
  function automatic table_result_t apply_table_op(cmd_t c, logic [8:0] h, logic [8:0] s);
    table_result_t r;
    logic [8:0]    hnd;
    logic [8:0]    moved;
    logic [8:0]    hole;
    r.st   = ST_OK;
    r.hnd  = '0;
    r.slot = '0;
    case (c)
      CMD_ALLOC: begin
        if (free_cnt == 0 || live_n >= TABLE_SIZE) begin
          r.st = ST_FULL;
        end else begin
          free_cnt--;
          hnd = free_list[free_cnt];
          handle_at[live_n] = hnd;
          slot_of[hnd] = 9'(live_n);
          touched[hnd] = 1'b1;
          r.hnd  = hnd;
          r.slot = 9'(live_n);
          live_n++;
        end
      end
      CMD_FREE: begin
        if (!handle_is_live(h) || free_cnt >= TABLE_SIZE) begin
          r.st = ST_NOT_LIVE;
        end else begin
          hole = slot_of[h];
          live_n--;
          moved = handle_at[live_n];
          slot_of[moved] = hole;
          handle_at[hole] = moved;
          free_list[free_cnt] = h;
          free_cnt++;
          r.hnd  = moved;
          r.slot = hole;
        end
      end
      CMD_READ: begin
        r.slot = s;
        if (int'(s) >= live_n) r.st = ST_BAD_SLOT;
        else r.hnd = handle_at[s];
      end
      default: ;
    endcase
    r.count = 10'(live_n);
    return r;
  endfunction

  function automatic bit pick_dead_handle(output logic [8:0] h);
    logic [8:0] cand[$];
    h = '0;
    for (int i = 0; i < TABLE_SIZE; i++)
      if (touched[i] && !handle_is_live(9'(i))) cand.push_back(9'(i));
    if (cand.size() == 0) return 1'b0;
    h = cand[$urandom_range(0, cand.size() - 1)];
    return 1'b1;
  endfunction

  task automatic send_word(input cmd_t c, input logic [8:0] h, input logic [8:0] s);
    int            gap;
    table_result_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    in_valid  <= 1'b1;
    command   <= c;
    handle_in <= h;
    slot_in   <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = apply_table_op(c, h, s);
    pending_results.push_back(r);
    burst_left--;
    case (c)
      CMD_ALLOC: n_alloc++;
      CMD_FREE:  n_free++;
      CMD_READ:  n_read++;
      default:   n_idle++;
    endcase
    case (r.st)
      ST_FULL:     n_full++;
      ST_NOT_LIVE: n_not_live++;
      ST_BAD_SLOT: n_bad_slot++;
      default: ;
    endcase
    if (live_n > peak_live) peak_live = live_n;
  endtask

  // Drop valid and hold off until every outstanding word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [8:0] any9();
    return 9'($urandom_range(0, TABLE_SIZE - 1));
  endfunction

  task automatic test_directed();
    send_word(CMD_READ, 9'h1FF, 9'h000);   // empty table
    send_word(CMD_READ, 9'h000, 9'h1FF);
    send_word(CMD_NONE, 9'h1FF, 9'h1FF);
    send_word(CMD_NONE, 9'h000, 9'h000);
    send_word(CMD_ALLOC, 9'h000, 9'h1FF);  // highest handle first
    send_word(CMD_ALLOC, 9'h1FF, 9'h000);
    send_word(CMD_ALLOC, 9'h0AA, 9'h155);
    send_word(CMD_READ, 9'h155, 9'd0);
    send_word(CMD_READ, 9'h0AA, 9'd1);
    send_word(CMD_READ, 9'h000, 9'd2);
    send_word(CMD_READ, 9'h1FF, 9'd3);     // first slot past the count
    send_word(CMD_FREE, 9'd511, 9'h1FF);   // hole at slot 0, last one moves in
    send_word(CMD_FREE, 9'd511, 9'h000);   // double free
    send_word(CMD_READ, 9'h000, 9'd0);
    send_word(CMD_FREE, 9'd510, 9'h0AA);   // freeing the last slot moves nothing
    send_word(CMD_ALLOC, 9'h155, 9'h0AA);  // LIFO reuse of the freed handle
    send_word(CMD_FREE, 9'd509, 9'h000);
    send_word(CMD_FREE, 9'd510, 9'h1FF);
    send_word(CMD_FREE, 9'd510, 9'h000);   // not live, count zero
    send_word(CMD_READ, 9'h1FF, 9'd0);
    drain_results();
  endtask

  task automatic test_fill_and_drain();
    while (free_cnt > 0) send_word(CMD_ALLOC, any9(), any9());
    send_word(CMD_ALLOC, 9'h1FF, 9'h1FF);  // full
    send_word(CMD_ALLOC, 9'h000, 9'h000);
    send_word(CMD_READ, any9(), 9'd511);
    send_word(CMD_READ, any9(), 9'd0);
    send_word(CMD_FREE, handle_at[TABLE_SIZE - 1], any9());
    send_word(CMD_ALLOC, any9(), any9());
    send_word(CMD_FREE, handle_at[0], any9());
    send_word(CMD_ALLOC, any9(), any9());
    drain_results();
    while (live_n > 0) begin
      if ($urandom_range(0, 9) == 0) send_word(CMD_READ, any9(), any9());
      else send_word(CMD_FREE, handle_at[$urandom_range(0, live_n - 1)], any9());
    end
    send_word(CMD_FREE, any9(), any9());   // every handle touched, none live
    send_word(CMD_READ, any9(), 9'd0);
    drain_results();
  endtask

  task automatic test_random();
    int         seg_left;
    int         alloc_pct;
    int         pick;
    logic [8:0] h;
    seg_left  = 0;
    alloc_pct = 60;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (seg_left == 0) begin
        seg_left  = $urandom_range(40, 200);
        alloc_pct = (alloc_pct > 40) ? $urandom_range(15, 30) : $urandom_range(55, 75);
      end
      seg_left--;
      if (n == RANDOM_WORDS / 2) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) begin
        send_word(CMD_ALLOC, any9(), any9());
      end else if (pick < 82 && live_n > 0) begin
        send_word(CMD_FREE, handle_at[$urandom_range(0, live_n - 1)], any9());
      end else if (pick < 88 && live_n > 0) begin
        send_word(CMD_READ, any9(), 9'($urandom_range(0, live_n - 1)));
      end else if (pick < 92) begin
        send_word(CMD_READ, any9(),
                  (live_n < TABLE_SIZE) ? 9'($urandom_range(live_n, TABLE_SIZE - 1))
                                        : any9());
      end else if (pick < 96) begin
        if (pick_dead_handle(h)) send_word(CMD_FREE, h, any9());
        else send_word(CMD_READ, any9(), any9());
      end else begin
        send_word(CMD_NONE, any9(), any9());
      end
    end
    drain_results();
  endtask

  // Receiver: picks a new stall habit (always ready, a rotating pattern or random) whenever its hold counter runs out.
  always @(posedge clk) begin : receiver
    static int          rx_hold = 0;
    static int          rx_mode = 0;
    static logic [15:0] rx_pattern = 16'hFFFF;
    if (rx_hold == 0) begin
      rx_hold    = $urandom_range(50, 300);
      rx_mode    = $urandom_range(0, 2);
      rx_pattern = 16'($urandom) | 16'h0001;
    end
    rx_hold--;
    rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= rx_pattern[0];
      default: out_ready <= ($urandom_range(0, 99) >= 35);
    endcase
  end

  always @(posedge clk) begin : check_results
    table_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: status %0d handle %0d slot %0d count %0d",
               status, handle_out, slot_out, live_count_out);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (status !== exp_r.st) begin
          $error("status: expected %0d, got %0d", exp_r.st, status);
          errors++;
        end
        if (handle_out !== exp_r.hnd) begin
          $error("handle_out: expected %0d, got %0d", exp_r.hnd, handle_out);
          errors++;
        end
        if (slot_out !== exp_r.slot) begin
          $error("slot_out: expected %0d, got %0d", exp_r.slot, slot_out);
          errors++;
        end
        if (live_count_out !== exp_r.count) begin
          $error("live_count_out: expected %0d, got %0d", exp_r.count, live_count_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    reset_mirror();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fill_and_drain();
    test_random();
    repeat (16) @(posedge clk);
    $display("%0d words: %0d allocate, %0d free, %0d read, %0d unused code; peak count %0d",
             n_alloc + n_free + n_read + n_idle, n_alloc, n_free, n_read, n_idle, peak_live);
    $display("rejected words: %0d table full, %0d handle not live, %0d slot past count",
             n_full, n_not_live, n_bad_slot);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
